// File: rtl/bfir_pkg.sv
// Shared types and constants of the box filter image resampler.
package bfir_pkg;

  localparam int unsigned MaxSourceWidth  = 256;
  localparam int unsigned MaxSourceHeight = 256;
  localparam int unsigned MaxDestWidth    = 512;
  localparam int unsigned MaxChannels     = 4;
  localparam int unsigned StoreDepth      = MaxSourceWidth * MaxSourceHeight;
  localparam int unsigned StoreAw         = $clog2(StoreDepth);

  // Iterative divider sizes: dividend holds the vertical position numerator
  localparam int unsigned DivNumW = 27;
  localparam int unsigned DivDenW = 19;

  // Register indexes on the configuration port
  localparam logic [2:0] RegSrcW  = 3'd0;
  localparam logic [2:0] RegSrcH  = 3'd1;
  localparam logic [2:0] RegDstW  = 3'd2;
  localparam logic [2:0] RegDstH  = 3'd3;
  localparam logic [2:0] RegChan  = 3'd4;
  localparam logic [2:0] RegScale = 3'd5;
  localparam logic [2:0] RegOffX  = 3'd6;
  localparam logic [2:0] RegOffY  = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } in_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic       last_pixel;
  } out_t;

  typedef struct packed {
    logic [9:0] near_w;
    logic [9:0] mid_w;
    logic [9:0] far_w;
  } wgt_t;

endpackage

// File: rtl/box_filter_image_resampler.sv
// Box filter image resampler: source store, geometry sequencer and 3x3 weighted sum.
// A load beat writes one source pixel into the 64K x 32 source memory. An emit beat
// runs seven divisions on a shared restoring divider of 27 steps, each followed by an
// unload state (footprint, horizontal and vertical source position, and one per
// channel for the normalization by footprint squared), the weight setup, nine neighbor
// reads on the single memory port, each through an address, read and accumulate
// state, three column accumulation steps and a hand-off of the result.
// A finished pixel waits in the output register while load beats keep flowing.
module box_filter_image_resampler
  import bfir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_DVE  = 4'd2;
  localparam logic [3:0] S_WGT  = 4'd3;
  localparam logic [3:0] S_ADDR = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_COL  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [1:0] PH_FP = 2'd0;
  localparam logic [1:0] PH_SX = 2'd1;
  localparam logic [1:0] PH_SY = 2'd2;
  localparam logic [1:0] PH_CH = 2'd3;

  localparam logic [4:0] DivLast = 5'(DivNumW - 1);

  // Configuration registers
  logic [8:0] src_w_q, src_h_q, scale_q, offx_q, offy_q;
  logic [9:0] dst_w_q, dst_h_q;
  logic [2:0] chan_q;

  // Control state
  logic [3:0]  state_q;
  logic [1:0]  phase_q;
  logic [4:0]  dcnt_q;
  logic [1:0]  i_q, j_q, ch_q;
  logic [15:0] load_idx_q;
  logic [9:0]  out_col_q, out_row_q, cur_col_q, cur_row_q;
  logic [19:0] src_x_q;
  logic        out_valid_q;
  out_t        out_q;

  // Datapath registers
  logic [DivNumW-1:0] dquo_q;
  logic [DivDenW-1:0] dden_q;
  logic [DivDenW-1:0] drem_q;
  logic [9:0]         fp_q;
  logic [19:0]        sx_q;
  logic [15:0]        sy_q;
  logic [18:0]        foo_q;
  logic [7:0]         rows_q [3];
  logic [7:0]         cols_q [3];
  logic [9:0]         wy_q [3];
  logic [9:0]         wx_q [3];
  logic [16:0]        part_q [MaxChannels];
  logic [25:0]        acc_q [MaxChannels];
  logic [7:0]         res_q [MaxChannels];
  logic [StoreAw-1:0] addr_q;
  logic [31:0]        rdata_q;
  logic [31:0]        mem_q [StoreDepth];

  // Effective (saturated) configuration
  logic [8:0] w_eff, h_eff, s_eff;
  logic [9:0] dw_eff, dh_eff;
  logic [2:0] nch_eff;

  always_comb begin
    w_eff   = (src_w_q < 9'd3) ? 9'd3 : ((src_w_q > 9'(MaxSourceWidth)) ?
              9'(MaxSourceWidth) : src_w_q);
    h_eff   = (src_h_q < 9'd3) ? 9'd3 : ((src_h_q > 9'(MaxSourceHeight)) ?
              9'(MaxSourceHeight) : src_h_q);
    dw_eff  = (dst_w_q == 10'd0) ? 10'd1 : ((dst_w_q > 10'(MaxDestWidth)) ?
              10'(MaxDestWidth) : dst_w_q);
    dh_eff  = (dst_h_q == 10'd0) ? 10'd1 : dst_h_q;
    nch_eff = (chan_q == 3'd0) ? 3'd1 : ((chan_q > 3'(MaxChannels)) ?
              3'(MaxChannels) : chan_q);
    s_eff   = (scale_q < 9'd128) ? 9'd128 : ((scale_q > 9'd510) ? 9'd510 : scale_q);
  end

  // APB register file
  logic       cfg_we;
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      RegSrcW:  prdata = {23'd0, src_w_q};
      RegSrcH:  prdata = {23'd0, src_h_q};
      RegDstW:  prdata = {22'd0, dst_w_q};
      RegDstH:  prdata = {22'd0, dst_h_q};
      RegChan:  prdata = {29'd0, chan_q};
      RegScale: prdata = {23'd0, scale_q};
      RegOffX:  prdata = {23'd0, offx_q};
      RegOffY:  prdata = {23'd0, offy_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 10'd256;
      dst_h_q <= 10'd256;
      chan_q  <= 3'd4;
      scale_q <= 9'd256;
      offx_q  <= 9'd0;
      offy_q  <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegSrcW:  src_w_q <= pwdata[8:0];
        RegSrcH:  src_h_q <= pwdata[8:0];
        RegDstW:  dst_w_q <= pwdata[9:0];
        RegDstH:  dst_h_q <= pwdata[9:0];
        RegChan:  chan_q  <= pwdata[2:0];
        RegScale: scale_q <= pwdata[8:0];
        RegOffX:  offx_q  <= pwdata[8:0];
        RegOffY:  offy_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Input handshake and load address
  logic        in_fire, load_fire, emit_fire;
  logic [16:0] total;
  logic [15:0] load_idx;
  logic [16:0] load_nxt;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign load_fire  = in_fire & ~in_i.mode;
  assign emit_fire  = in_fire & in_i.mode;
  assign total      = 17'(w_eff * h_eff);
  assign load_idx   = ({1'b0, load_idx_q} < total) ? load_idx_q : 16'd0;
  assign load_nxt   = {1'b0, load_idx} + 17'd1;

  // Emit start position: wrap column into next row, row into image
  logic [10:0] row_inc;
  logic [9:0]  col_start, row_start;
  always_comb begin
    col_start = out_col_q;
    row_inc   = {1'b0, out_row_q};
    if (out_col_q >= dw_eff) begin
      col_start = 10'd0;
      row_inc   = {1'b0, out_row_q} + 11'd1;
    end
    row_start = (row_inc >= {1'b0, dh_eff}) ? 10'd0 : row_inc[9:0];
  end

  // Divider step
  logic [DivDenW:0]   rem_sh;
  logic               dge;
  logic [DivDenW-1:0] drem_nxt;
  logic [DivNumW-1:0] dquo_nxt;
  assign rem_sh   = {drem_q, dquo_q[DivNumW-1]};
  assign dge      = rem_sh >= {1'b0, dden_q};
  assign drem_nxt = dge ? DivDenW'(rem_sh - {1'b0, dden_q}) : rem_sh[DivDenW-1:0];
  assign dquo_nxt = {dquo_q[DivNumW-2:0], dge};

  // Edge weights from a fractional position
  function automatic wgt_t edge_w(input logic [7:0] d, input logic [9:0] fp);
    logic [8:0] half;
    logic [7:0] t;
    wgt_t       r;
    half = fp[9:1];
    t    = 8'd255 - d;
    r.near_w = ({1'b0, d} > half) ? 10'd0 : 10'({1'b0, half} - {2'b0, d});
    r.far_w  = ({1'b0, t} > half) ? 10'd0 : 10'({1'b0, half} - {2'b0, t});
    r.mid_w  = fp - r.near_w - r.far_w;
    return r;
  endfunction

  wgt_t       wy, wx;
  logic [7:0] row_c, col_c;
  logic [11:0] col_raw;
  logic [8:0]  w_m1;
  assign wy      = edge_w(sy_q[7:0], fp_q);
  assign wx      = edge_w(sx_q[7:0], fp_q);
  assign row_c   = sy_q[15:8];
  assign col_raw = sx_q[19:8];
  assign w_m1    = w_eff - 9'd1;
  assign col_c   = (col_raw > {3'd0, w_m1}) ? w_m1[7:0] : col_raw[7:0];

  // Vertical position clamp
  logic [19:0] sy_div;
  logic [16:0] sy_lim;
  assign sy_div = dquo_q[19:0];
  assign sy_lim = {(h_eff - 9'd1), 8'd0};

  // Source memory
  logic mem_we, mem_re;
  assign mem_we = load_fire;
  assign mem_re = (state_q == S_RD);
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[load_idx[StoreAw-1:0]] <= {in_i.chan3_in, in_i.chan2_in,
                                       in_i.chan1_in, in_i.chan0_in};
    end
    if (mem_re) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  logic out_take;
  assign out_take = out_valid_q & out_ready_i;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FP;
      dcnt_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ch_q        <= '0;
      load_idx_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      src_x_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_fire) begin
            load_idx_q <= (load_nxt >= total) ? 16'd0 : load_nxt[15:0];
          end
          if (emit_fire) begin
            cur_col_q <= col_start;
            cur_row_q <= row_start;
            phase_q   <= PH_FP;
            dquo_q    <= DivNumW'(17'h10000);
            dden_q    <= DivDenW'(s_eff);
            drem_q    <= '0;
            dcnt_q    <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          drem_q <= drem_nxt;
          dquo_q <= dquo_nxt;
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == DivLast) begin
            state_q <= S_DVE;
          end
        end
        S_DVE: begin
          dcnt_q <= '0;
          drem_q <= '0;
          state_q <= S_DIV;
          unique case (phase_q)
            PH_FP: begin
              fp_q    <= dquo_q[9:0];
              phase_q <= PH_SX;
              dquo_q  <= DivNumW'({offx_q, 8'd0});
            end
            PH_SX: begin
              sx_q    <= (cur_col_q == 10'd0) ? dquo_q[19:0] : src_x_q;
              phase_q <= PH_SY;
              dquo_q  <= DivNumW'({({cur_row_q, 8'd0} + {9'd0, offy_q}), 8'd0});
            end
            PH_SY: begin
              sy_q    <= ({3'd0, sy_div} >= {6'd0, sy_lim}) ?
                         {(h_eff[7:0] - 8'd2), 8'd0} : sy_div[15:0];
              state_q <= S_WGT;
            end
            PH_CH: begin
              res_q[ch_q] <= ({1'b0, ch_q} < nch_eff) ? dquo_q[7:0] : 8'd0;
              if (ch_q == 2'd3) begin
                state_q <= S_FIN;
              end else begin
                ch_q   <= ch_q + 2'd1;
                dquo_q <= DivNumW'(acc_q[ch_q + 2'd1]);
              end
            end
            default: ;
          endcase
        end
        S_WGT: begin
          foo_q     <= 19'(fp_q * fp_q);
          wy_q[0]   <= wy.near_w;
          wy_q[1]   <= wy.mid_w;
          wy_q[2]   <= wy.far_w;
          wx_q[0]   <= wx.near_w;
          wx_q[1]   <= wx.mid_w;
          wx_q[2]   <= wx.far_w;
          rows_q[0] <= (row_c == 8'd0) ? row_c : row_c - 8'd1;
          rows_q[1] <= row_c;
          rows_q[2] <= ({1'b0, row_c} + 9'd1 >= h_eff) ? row_c : row_c + 8'd1;
          cols_q[0] <= (col_c == 8'd0) ? col_c : col_c - 8'd1;
          cols_q[1] <= col_c;
          cols_q[2] <= ({1'b0, col_c} + 9'd1 >= w_eff) ? col_c : col_c + 8'd1;
          for (int c = 0; c < MaxChannels; c++) begin
            part_q[c] <= '0;
            acc_q[c]  <= '0;
          end
          i_q     <= '0;
          j_q     <= '0;
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          addr_q  <= StoreAw'(rows_q[i_q] * w_eff + {9'd0, cols_q[j_q]});
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          for (int c = 0; c < MaxChannels; c++) begin
            part_q[c] <= part_q[c] + 17'(rdata_q[8*c +: 8] * wy_q[i_q]);
          end
          if (i_q == 2'd2) begin
            i_q     <= '0;
            state_q <= S_COL;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= S_ADDR;
          end
        end
        S_COL: begin
          for (int c = 0; c < MaxChannels; c++) begin
            acc_q[c]  <= acc_q[c] + 26'(wx_q[j_q] * part_q[c]);
            part_q[c] <= '0;
          end
          if (j_q == 2'd2) begin
            ch_q    <= '0;
            phase_q <= PH_CH;
            state_q <= S_DIV;
            dcnt_q  <= '0;
            drem_q  <= '0;
            dden_q  <= foo_q;
            dquo_q  <= DivNumW'(acc_q[0] + 26'(wx_q[j_q] * part_q[0]));
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= S_ADDR;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.chan0_out     <= res_q[0];
            out_q.chan1_out     <= res_q[1];
            out_q.chan2_out     <= res_q[2];
            out_q.chan3_out     <= res_q[3];
            out_q.last_pixel    <= (cur_col_q == dw_eff - 10'd1) &&
                                   (cur_row_q == dh_eff - 10'd1);
            src_x_q             <= sx_q + {10'd0, fp_q};
            if ({1'b0, cur_col_q} + 11'd1 >= {1'b0, dw_eff}) begin
              out_col_q <= '0;
              out_row_q <= ({1'b0, cur_row_q} + 11'd1 >= {1'b0, dh_eff}) ?
                           10'd0 : cur_row_q + 10'd1;
            end else begin
              out_col_q <= cur_col_q + 10'd1;
              out_row_q <= cur_row_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/bfir_checker.sv
// Port-level checks of the box filter image resampler.
module bfir_checker
  import bfir_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o,
  input logic pready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat dropped or changed");

  // Config port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // An accepted beat never produces a result in the next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared right after an input beat");

  // An emit beat keeps the input closed while the pixel is computed
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.mode |=> !in_ready_o)
    else $error("input open during pixel computation");

endmodule

bind box_filter_image_resampler bfir_checker u_bfir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o),
  .pready      (pready)
);

// File: sim/testbench.sv
// Self-checking testbench for the box filter image resampler.
`timescale 1ns / 100ps

module testbench;
  import bfir_pkg::*;

  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned SettleCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_filter_image_resampler u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // Shadow registers and filter state
  int unsigned cfg_src_w = 256, cfg_src_h = 256, cfg_dst_w = 256, cfg_dst_h = 256;
  int unsigned cfg_chan = 4, cfg_scale = 256, cfg_off_x = 0, cfg_off_y = 0;
  logic [31:0] pixel_mem [0:StoreDepth-1];
  int unsigned load_idx = 0, dst_col = 0, dst_row = 0;
  logic [19:0] src_x_q8 = '0;

  in_t  pending_beats[$];
  out_t expected_pixels[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit random_started = 1'b0;
  bit hold_long = 1'b0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void edge_wts(input int unsigned d, input int unsigned fp,
                                   output int unsigned nw, output int unsigned mw,
                                   output int unsigned fw);
    int unsigned half;
    half = fp / 2;
    nw = (d > half) ? 0 : half - d;
    fw = ((255 - d) > half) ? 0 : half - (255 - d);
    mw = fp - nw - fw;
  endfunction

  // Apply one accepted beat to the filter state; queue the pixel it yields
  function automatic void filter_beat(in_t beat);
    int unsigned w, h, total, idx, dw, dh, scl, nch, fp, fsq, sx, sy, row, col, acc, part;
    int unsigned wy[3], wx[3], rws[3], cls[3];
    logic [31:0] word;
    out_t px;
    w = clamp(cfg_src_w, 3, MaxSourceWidth);
    h = clamp(cfg_src_h, 3, MaxSourceHeight);
    total = w * h;
    if (beat.mode == 1'b0) begin
      idx = load_idx < total ? load_idx : 0;
      pixel_mem[idx] = {beat.chan3_in, beat.chan2_in, beat.chan1_in, beat.chan0_in};
      load_idx = (idx + 1 >= total) ? 0 : idx + 1;
      return;
    end
    dw = clamp(cfg_dst_w, 1, MaxDestWidth);
    dh = cfg_dst_h < 1 ? 1 : cfg_dst_h;
    scl = clamp(cfg_scale, 128, 510);
    nch = clamp(cfg_chan, 1, MaxChannels);
    fp = 65536 / scl;
    fsq = fp * fp;
    if (dst_col >= dw) begin
      dst_col = 0;
      dst_row++;
    end
    if (dst_row >= dh) dst_row = 0;
    sx = (dst_col == 0) ? (cfg_off_x * 256) / scl : src_x_q8;
    sy = ((dst_row * 256 + cfg_off_y) * 256) / scl;
    if (sy >= ((h - 1) << 8)) sy = (h - 2) << 8;
    edge_wts(sy & 255, fp, wy[0], wy[1], wy[2]);
    edge_wts(sx & 255, fp, wx[0], wx[1], wx[2]);
    row = sy >> 8;
    col = sx >> 8;
    if (col > w - 1) col = w - 1;
    rws[0] = row == 0 ? row : row - 1;
    rws[1] = row;
    rws[2] = row + 1 >= h ? row : row + 1;
    cls[0] = col == 0 ? col : col - 1;
    cls[1] = col;
    cls[2] = col + 1 >= w ? col : col + 1;
    px = '0;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      if (c < nch) begin
        for (int j = 0; j < 3; j++) begin
          part = 0;
          for (int i = 0; i < 3; i++) begin
            word = pixel_mem[(rws[i] * w + cls[j]) % StoreDepth];
            part += ((word >> (8 * c)) & 32'hff) * wy[i];
          end
          acc += wx[j] * part;
        end
        acc /= fsq;
      end
      case (c)
        0: px.chan0_out = acc[7:0];
        1: px.chan1_out = acc[7:0];
        2: px.chan2_out = acc[7:0];
        default: px.chan3_out = acc[7:0];
      endcase
    end
    px.last_pixel = (dst_col == dw - 1) && (dst_row == dh - 1);
    expected_pixels.push_back(px);
    src_x_q8 = 20'(sx + fp);
    dst_col++;
    if (dst_col >= dw) begin
      dst_col = 0;
      dst_row++;
      if (dst_row >= dh) dst_row = 0;
    end
  endfunction

  // Source side: offer queued beats in bursts with gaps in between
  int unsigned burst_left = 1, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) filter_beat(in_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: stall in random stretches, with quiet periods of full throughput
  int unsigned stall_left = 0, quiet_left = 0;
  always @(posedge clk_i) begin
    if (hold_long) begin
      out_ready_i <= 1'b0;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0: quiet_left = $urandom_range(200, 2000);
        1, 2: stall_left = $urandom_range(1, 300);
        default: ;
      endcase
      out_ready_i <= 1'b1;
    end
  end

  // Compare each delivered pixel with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected pixel %h", out_o);
      end else begin
        want = expected_pixels.pop_front();
        if (out_o !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"pixel mismatch: expected c0=%h c1=%h c2=%h c3=%h last=%b,",
                      " got c0=%h c1=%h c2=%h c3=%h last=%b"},
                     want.chan0_out, want.chan1_out, want.chan2_out, want.chan3_out,
                     want.last_pixel, out_o.chan0_out, out_o.chan1_out, out_o.chan2_out,
                     out_o.chan3_out, out_o.last_pixel);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold off the result side for a long stretch once random traffic runs
  initial begin
    wait (random_started);
    repeat (3000) @(negedge clk_i);
    hold_long = 1'b1;
    repeat (5000) @(negedge clk_i);
    hold_long = 1'b0;
  end

  task automatic reg_write(logic [2:0] idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegSrcW:  cfg_src_w = val & 32'h1ff;
      RegSrcH:  cfg_src_h = val & 32'h1ff;
      RegDstW:  cfg_dst_w = val & 32'h3ff;
      RegDstH:  cfg_dst_h = val & 32'h3ff;
      RegChan:  cfg_chan  = val & 32'h7;
      RegScale: cfg_scale = val & 32'h1ff;
      RegOffX:  cfg_off_x = val & 32'h1ff;
      default:  cfg_off_y = val & 32'h1ff;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic in_t rand_beat(bit emit);
    in_t b;
    b = in_t'({1'b0, $urandom});
    b.mode = emit;
    return b;
  endfunction

  // Reconfigure while idle, load a full image, then queue mixed traffic
  task automatic run_image(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                           int unsigned nch, int unsigned scl, int unsigned ox,
                           int unsigned oy, int unsigned n_mixed, int unsigned emit_pct);
    int unsigned total;
    wait_idle();
    repeat (SettleCycles) @(negedge clk_i);
    reg_write(RegSrcW, sw);
    reg_write(RegSrcH, sh);
    reg_write(RegDstW, dw);
    reg_write(RegDstH, dh);
    reg_write(RegChan, nch);
    reg_write(RegScale, scl);
    reg_write(RegOffX, ox);
    reg_write(RegOffY, oy);
    total = clamp(cfg_src_w, 3, MaxSourceWidth) * clamp(cfg_src_h, 3, MaxSourceHeight);
    for (int unsigned k = 0; k < total; k++) pending_beats.push_back(rand_beat(1'b0));
    for (int unsigned k = 0; k < n_mixed; k++)
      pending_beats.push_back(rand_beat($urandom_range(0, 99) < emit_pct));
  endtask

  initial begin
    in_t b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x3 image at unit scale with extreme channel values, full output plus wrap
    wait_idle();
    reg_write(RegSrcW, 3);
    reg_write(RegSrcH, 3);
    reg_write(RegDstW, 3);
    reg_write(RegDstH, 3);
    reg_write(RegChan, 4);
    reg_write(RegScale, 256);
    reg_write(RegOffX, 0);
    reg_write(RegOffY, 0);
    for (int k = 0; k < 9; k++) begin
      b = '0;
      case (k % 3)
        0: b = '{mode: 1'b0, chan0_in: 8'hff, chan1_in: 8'h00, chan2_in: 8'hff,
                 chan3_in: 8'h00};
        1: b = '{mode: 1'b0, chan0_in: 8'h00, chan1_in: 8'hff, chan2_in: 8'h55,
                 chan3_in: 8'haa};
        default: b = '{mode: 1'b0, chan0_in: 8'haa, chan1_in: 8'h55, chan2_in: 8'h00,
                       chan3_in: 8'hff};
      endcase
      pending_beats.push_back(b);
    end
    for (int k = 0; k < 10; k++) pending_beats.push_back(rand_beat(1'b1));

    // Extreme and out-of-range settings
    run_image(0, 511, 0, 0, 0, 0, 511, 0, 30, 60);
    run_image(511, 0, 1023, 1023, 7, 511, 0, 511, 30, 60);
    run_image(4, 4, 2, 2, 3, 510, 509, 0, 20, 70);

    // Random settings, mostly small images
    random_started = 1'b1;
    for (int p = 0; p < 5; p++)
      run_image($urandom_range(3, 14), $urandom_range(3, 14),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 12),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 12),
                $urandom_range(0, 7),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(128, 510),
                $urandom_range(0, 511), $urandom_range(0, 511), 40, 50);

    wait_idle();
    repeat (SettleCycles) @(negedge clk_i);
    if (err_cnt == 0 && expected_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bfir_pkg.sv
rtl/box_filter_image_resampler.sv
rtl/bfir_checker.sv
sim/testbench.sv
